// File: rtl/circular_roi_mean_stddev_top_assert.svh
// Assertion macros for the circular ROI mean / std dev block.
// Used by the checker attached to the top level; no dependencies.
`ifndef CIRCULAR_ROI_MEAN_STDDEV_TOP_ASSERT_SVH
`define CIRCULAR_ROI_MEAN_STDDEV_TOP_ASSERT_SVH

// clocked assertion, masked while reset is active
`define CRMS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define CRMS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/crms_pkg.sv
// Package for the circular ROI mean / std dev block: field widths, register
// codes, reset values, payload and control types, width helper functions.
package crms_pkg;

  localparam int SIDE_W      = 12;
  localparam int CTR_W       = 13;
  localparam int RAD_W       = 12;
  localparam int PIX_W       = 20;
  localparam int STD_W       = 20;
  localparam int CNT_OUT_W   = 23;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 2;

  localparam int MAX_SIDE_DEF   = 2048;
  localparam int PIXEL_BITS_DEF = 20;

  localparam logic [SIDE_W-1:0] SIDE_RST   = 12'd1024;
  localparam logic [CTR_W-1:0]  CENTER_RST = 13'd512;
  localparam logic [RAD_W-1:0]  RADIUS_RST = 12'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIDE     = 2'd0,
    REG_CENTER_X = 2'd1,
    REG_CENTER_Y = 2'd2,
    REG_RADIUS   = 2'd3
  } crms_reg_e;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_value;
    logic                    last_pixel;
  } crms_pix_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] mean_value;
    logic [STD_W-1:0]        roi_std_dev;
    logic [CNT_OUT_W-1:0]    roi_count;
    logic                    roi_empty;
  } crms_res_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL_A_LOAD,
    OP_MUL_B_LOAD,
    OP_MUL_C_LOAD,
    OP_MUL_STEP,
    OP_DIV_V_LOAD,
    OP_DIV_M_LOAD,
    OP_DIV_STEP,
    OP_SQRT_LOAD,
    OP_SQRT_STEP,
    OP_RESULT,
    OP_EMPTY_RESULT
  } crms_op_e;

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_CHECK,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_DIV_V,
    ST_LOAD_M,
    ST_DIV_M,
    ST_LOAD_S,
    ST_SQRT,
    ST_FINISH
  } crms_state_e;

  typedef struct packed {
    crms_op_e op;
    logic     accept;
    logic     in_ready;
    logic     out_valid;
  } crms_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic empty;
  } crms_sts_t;

  function automatic int pos_w(int max_side);
    return $clog2(max_side);
  endfunction

  function automatic int cnt_w(int max_side);
    return 2 * $clog2(max_side) + 1;
  endfunction

  function automatic int sum_w(int max_side, int pix_bits);
    return pix_bits + cnt_w(max_side);
  endfunction

  function automatic int sq_w(int max_side, int pix_bits);
    return 2 * pix_bits + cnt_w(max_side) - 1;
  endfunction

  function automatic int prod_w(int max_side, int pix_bits);
    return cnt_w(max_side) + sq_w(max_side, pix_bits);
  endfunction

  function automatic int dx_w(int max_side);
    return ((pos_w(max_side) + 1 > CTR_W) ? pos_w(max_side) + 1 : CTR_W) + 1;
  endfunction

endpackage

// File: rtl/crms_stream_if.sv
// Valid/ready stream interfaces for pixel requests and results.
// Depends on crms_pkg for the payload types.
interface crms_pix_if;
  logic                valid;
  logic                ready;
  crms_pkg::crms_pix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface crms_res_if;
  logic                valid;
  logic                ready;
  crms_pkg::crms_res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/crms_ctrl.sv
// Controller FSM: pixel streaming, then sequencing of the serial multiply,
// divide and square root passes. Depends on crms_pkg.
module crms_ctrl #(
  parameter int MAX_SIDE   = crms_pkg::MAX_SIDE_DEF,
  parameter int PIXEL_BITS = crms_pkg::PIXEL_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  input  logic                out_ready_i,
  input  crms_pkg::crms_sts_t sts_i,
  output crms_pkg::crms_cmd_t cmd_o
);
  import crms_pkg::*;

  localparam int PROD_W = prod_w(MAX_SIDE, PIXEL_BITS);
  localparam int STEP_W = $clog2(PROD_W);

  crms_state_e       state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              div_last, sqrt_last, accept;
  logic              out_vld_q, out_vld_d, res_load;

  assign div_last  = (step_q == STEP_W'(PROD_W - 1));
  assign sqrt_last = (step_q == STEP_W'(PIXEL_BITS - 1));
  assign accept    = in_valid_i && (state_q == ST_ACCUM);
  assign res_load  = (state_q == ST_FINISH) || ((state_q == ST_CHECK) && sts_i.empty);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_ACCUM;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_ACCUM:  if (accept && in_last_i) state_d = ST_DRAIN;
      ST_DRAIN:  if (!out_vld_q) state_d = ST_CHECK;
      ST_CHECK:  state_d = sts_i.empty ? ST_ACCUM : ST_MUL_A;
      ST_MUL_A:  if (sts_i.mul_done) state_d = ST_MUL_B;
      ST_MUL_B:  if (sts_i.mul_done) state_d = ST_MUL_C;
      ST_MUL_C:  if (sts_i.mul_done) state_d = ST_DIV_V;
      ST_DIV_V:  if (div_last) state_d = ST_LOAD_M;
      ST_LOAD_M: state_d = ST_DIV_M;
      ST_DIV_M:  if (div_last) state_d = ST_LOAD_S;
      ST_LOAD_S: state_d = ST_SQRT;
      ST_SQRT:   if (sqrt_last) state_d = ST_FINISH;
      ST_FINISH: state_d = ST_ACCUM;
      default:   state_d = ST_ACCUM;
    endcase
  end

  always_comb begin
    step_d = '0;
    case (state_q)
      ST_DIV_V, ST_DIV_M, ST_SQRT: step_d = step_q + STEP_W'(1);
      default:                     step_d = '0;
    endcase
  end

  // result slot: set when a result is loaded, freed when it is taken
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && out_ready_i) out_vld_d = 1'b0;
    if (res_load) out_vld_d = 1'b1;
  end

  always_comb begin
    cmd_o.op        = OP_NONE;
    cmd_o.accept    = accept;
    cmd_o.in_ready  = (state_q == ST_ACCUM);
    cmd_o.out_valid = out_vld_q;
    case (state_q)
      ST_CHECK:  cmd_o.op = sts_i.empty ? OP_EMPTY_RESULT : OP_MUL_A_LOAD;
      ST_MUL_A:  cmd_o.op = sts_i.mul_done ? OP_MUL_B_LOAD : OP_MUL_STEP;
      ST_MUL_B:  cmd_o.op = sts_i.mul_done ? OP_MUL_C_LOAD : OP_MUL_STEP;
      ST_MUL_C:  cmd_o.op = sts_i.mul_done ? OP_DIV_V_LOAD : OP_MUL_STEP;
      ST_DIV_V:  cmd_o.op = OP_DIV_STEP;
      ST_LOAD_M: cmd_o.op = OP_DIV_M_LOAD;
      ST_DIV_M:  cmd_o.op = OP_DIV_STEP;
      ST_LOAD_S: cmd_o.op = OP_SQRT_LOAD;
      ST_SQRT:   cmd_o.op = OP_SQRT_STEP;
      ST_FINISH: cmd_o.op = OP_RESULT;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// File: rtl/crms_datapath.sv
// Datapath: config registers, position counters, two-stage ROI accumulator,
// shift-add multiplier, restoring divider, digit-serial square root.
// Depends on crms_pkg; driven by crms_ctrl commands.
module crms_datapath #(
  parameter int MAX_SIDE   = crms_pkg::MAX_SIDE_DEF,
  parameter int PIXEL_BITS = crms_pkg::PIXEL_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [crms_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [crms_pkg::CFG_W-1:0]            cfg_wdata_i,
  input  crms_pkg::crms_cmd_t                   cmd_i,
  input  logic signed [crms_pkg::PIX_W-1:0]     pix_value_i,
  input  logic                                  pix_last_i,
  output crms_pkg::crms_sts_t                   sts_o,
  output crms_pkg::crms_res_t                   res_o
);
  import crms_pkg::*;

  localparam int POS_W  = pos_w(MAX_SIDE);
  localparam int CNT_W  = cnt_w(MAX_SIDE);
  localparam int SUM_W  = sum_w(MAX_SIDE, PIXEL_BITS);
  localparam int SQ_W   = sq_w(MAX_SIDE, PIXEL_BITS);
  localparam int PROD_W = prod_w(MAX_SIDE, PIXEL_BITS);
  localparam int DX_W   = dx_w(MAX_SIDE);
  localparam int DSQ_W  = 2 * DX_W + 1;
  localparam int RM_W   = 2 * CNT_W;
  localparam int VAR_W  = 2 * PIXEL_BITS;
  localparam int SR_W   = PIXEL_BITS + 2;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_SIDE * MAX_SIDE);

  // config
  logic [SIDE_W-1:0]        side_q;
  logic signed [CTR_W-1:0]  cx_q, cy_q;
  logic [RAD_W-1:0]         rad_q;
  logic [2*RAD_W-1:0]       r2_q;
  logic [SIDE_W-1:0]        side_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SIDE_RST;
      cx_q   <= CENTER_RST;
      cy_q   <= CENTER_RST;
      rad_q  <= RADIUS_RST;
    end else if (cfg_we_i) begin
      case (crms_reg_e'(cfg_idx_i))
        REG_SIDE:     side_q <= cfg_wdata_i[SIDE_W-1:0];
        REG_CENTER_X: cx_q   <= cfg_wdata_i[CTR_W-1:0];
        REG_CENTER_Y: cy_q   <= cfg_wdata_i[CTR_W-1:0];
        REG_RADIUS:   rad_q  <= cfg_wdata_i[RAD_W-1:0];
        default:      side_q <= side_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    r2_q <= rad_q * rad_q;
  end

  always_comb begin
    if (side_q == '0) side_eff = SIDE_W'(1);
    else if (side_q > SIDE_W'(MAX_SIDE)) side_eff = SIDE_W'(MAX_SIDE);
    else side_eff = side_q;
  end

  // position
  logic [POS_W-1:0]  col_q, row_q;
  logic [SIDE_W-1:0] col_inc, row_inc;

  assign col_inc = SIDE_W'(col_q) + SIDE_W'(1);
  assign row_inc = SIDE_W'(row_q) + SIDE_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.accept) begin
      if (pix_last_i) begin
        col_q <= '0;
        row_q <= '0;
      end else if (col_inc >= side_eff) begin
        col_q <= '0;
        row_q <= (row_inc >= side_eff) ? '0 : row_inc[POS_W-1:0];
      end else begin
        col_q <= col_inc[POS_W-1:0];
      end
    end
  end

  // stage 1: offsets squared, pixel squared
  logic signed [DX_W-1:0]         dx, dy;
  logic signed [PIXEL_BITS-1:0]   pix;
  logic signed [2*PIXEL_BITS-1:0] pix_sq;
  logic signed [2*DX_W-1:0]       dx_sq, dy_sq;
  logic                           s1_vld_q;
  logic signed [PIXEL_BITS-1:0]   s1_pix_q;
  logic [2*PIXEL_BITS-1:0]        s1_sq_q;
  logic [2*DX_W-1:0]              s1_dx2_q, s1_dy2_q;

  assign pix    = pix_value_i[PIXEL_BITS-1:0];
  assign dx     = DX_W'(signed'({1'b0, col_q})) - DX_W'(cx_q);
  assign dy     = DX_W'(signed'({1'b0, row_q})) - DX_W'(cy_q);
  assign pix_sq = pix * pix;
  assign dx_sq  = dx * dx;
  assign dy_sq  = dy * dy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else         s1_vld_q <= cmd_i.accept;
  end

  always_ff @(posedge clk_i) begin
    s1_pix_q <= pix;
    s1_sq_q  <= unsigned'(pix_sq);
    s1_dx2_q <= unsigned'(dx_sq);
    s1_dy2_q <= unsigned'(dy_sq);
  end

  // stage 2: accumulate
  logic [CNT_W-1:0]        cnt_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [SQ_W-1:0]         sqs_q;
  logic [DSQ_W-1:0]        dsq;
  logic                    hit;

  assign dsq = DSQ_W'(s1_dx2_q) + DSQ_W'(s1_dy2_q);
  assign hit = s1_vld_q && (dsq < DSQ_W'(r2_q)) && (cnt_q < CAP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      sqs_q <= '0;
    end else if (cmd_i.op == OP_RESULT || cmd_i.op == OP_EMPTY_RESULT) begin
      cnt_q <= '0;
      sum_q <= '0;
      sqs_q <= '0;
    end else if (hit) begin
      cnt_q <= cnt_q + CNT_W'(1);
      sum_q <= sum_q + SUM_W'(s1_pix_q);
      sqs_q <= sqs_q + SQ_W'(s1_sq_q);
    end
  end

  // final arithmetic
  logic             neg;
  logic [SUM_W-1:0] mag;

  assign neg = sum_q[SUM_W-1];
  assign mag = neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  logic [PROD_W-1:0] acc_q, mcand_q, pa_q, divn_q;
  logic [SUM_W-1:0]  mplier_q, mq_q;
  logic [RM_W-1:0]   rem_q, den_q, rem_d;
  logic [RM_W:0]     rem_sh;
  logic              div_ge;
  logic [VAR_W-1:0]  var_q, v_q;
  logic [SR_W-1:0]   srem_q, srem_d;
  logic [SR_W+1:0]   srem_sh, trial;
  logic              sq_ge;
  logic [PIXEL_BITS-1:0] root_q;
  logic [SUM_W:0]    mean_full;
  crms_res_t         res_q;

  assign rem_sh  = {rem_q, divn_q[PROD_W-1]};
  assign div_ge  = rem_sh >= {1'b0, den_q};
  assign rem_d   = div_ge ? RM_W'(rem_sh - {1'b0, den_q}) : rem_sh[RM_W-1:0];

  assign srem_sh = {srem_q, v_q[VAR_W-1 -: 2]};
  assign trial   = (SR_W + 2)'({root_q, 2'b01});
  assign sq_ge   = srem_sh >= trial;
  assign srem_d  = sq_ge ? SR_W'(srem_sh - trial) : srem_sh[SR_W-1:0];

  assign mean_full = neg ? ((SUM_W + 1)'(0) - {1'b0, mq_q}) : {1'b0, mq_q};

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_MUL_A_LOAD: begin
        acc_q    <= '0;
        mcand_q  <= PROD_W'(sqs_q);
        mplier_q <= SUM_W'(cnt_q);
      end
      OP_MUL_B_LOAD: begin
        pa_q     <= acc_q;
        acc_q    <= '0;
        mcand_q  <= PROD_W'(mag);
        mplier_q <= mag;
      end
      OP_MUL_C_LOAD: begin
        pa_q     <= pa_q - acc_q;
        acc_q    <= '0;
        mcand_q  <= PROD_W'(cnt_q);
        mplier_q <= SUM_W'(cnt_q);
      end
      OP_MUL_STEP: begin
        acc_q    <= acc_q + (mplier_q[0] ? mcand_q : '0);
        mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
        mplier_q <= mplier_q >> 1;
      end
      OP_DIV_V_LOAD: begin
        den_q  <= acc_q[RM_W-1:0];
        divn_q <= pa_q;
        rem_q  <= '0;
      end
      OP_DIV_M_LOAD: begin
        var_q  <= divn_q[VAR_W-1:0];
        den_q  <= RM_W'(cnt_q);
        divn_q <= neg ? PROD_W'(PROD_W'(mag) + PROD_W'(cnt_q) - PROD_W'(1))
                      : PROD_W'(mag);
        rem_q  <= '0;
      end
      OP_DIV_STEP: begin
        rem_q  <= rem_d;
        divn_q <= {divn_q[PROD_W-2:0], div_ge};
      end
      OP_SQRT_LOAD: begin
        mq_q   <= divn_q[SUM_W-1:0];
        v_q    <= var_q;
        srem_q <= '0;
        root_q <= '0;
      end
      OP_SQRT_STEP: begin
        srem_q <= srem_d;
        root_q <= {root_q[PIXEL_BITS-2:0], sq_ge};
        v_q    <= {v_q[VAR_W-3:0], 2'b00};
      end
      OP_RESULT: begin
        res_q.mean_value  <= PIX_W'(signed'(mean_full[PIXEL_BITS-1:0]));
        res_q.roi_std_dev <= STD_W'(root_q);
        res_q.roi_count   <= CNT_OUT_W'(cnt_q);
        res_q.roi_empty   <= 1'b0;
      end
      OP_EMPTY_RESULT: begin
        res_q.mean_value  <= '0;
        res_q.roi_std_dev <= '0;
        res_q.roi_count   <= '0;
        res_q.roi_empty   <= 1'b1;
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  assign sts_o.mul_done = (mplier_q == '0);
  assign sts_o.empty    = (cnt_q == '0);
  assign res_o          = res_q;

endmodule

// File: rtl/circular_roi_mean_stddev_top.sv
// Circular ROI mean and standard deviation over a raster pixel stream.
// Takes one pixel request per cycle while an image streams in. After the
// pixel marked last, the result follows a run of serial steps: a drain
// state that waits for the result slot to be free, a check state, three
// shift-add multiplies, two restoring divides each with a load step, a
// digit-serial square root and a finish state. An empty ROI skips the
// arithmetic and gives its result from the check state. The multiplier
// and divider work one bit at a time. Pixels are not taken from the last
// pixel until the result is loaded into the output register; a result not
// yet taken only holds the next image's last pixel in the drain state.
// Config must be written only while no image is in progress; the block
// itself does not enforce it.
// Depends on crms_pkg, crms_stream_if, crms_ctrl, crms_datapath.
module circular_roi_mean_stddev_top #(
  parameter int MAX_SIDE   = crms_pkg::MAX_SIDE_DEF,
  parameter int PIXEL_BITS = crms_pkg::PIXEL_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [crms_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [crms_pkg::CFG_W-1:0]     cfg_wdata_i,
  crms_pix_if.sink                       pix_i,
  crms_res_if.source                     res_o
);
  import crms_pkg::*;

  crms_cmd_t cmd;
  crms_sts_t sts;
  crms_res_t res;

  crms_ctrl #(
    .MAX_SIDE  (MAX_SIDE),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_last_i  (pix_i.data.last_pixel),
    .out_ready_i(res_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  crms_datapath #(
    .MAX_SIDE  (MAX_SIDE),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd),
    .pix_value_i(pix_i.data.pixel_value),
    .pix_last_i (pix_i.data.last_pixel),
    .sts_o      (sts),
    .res_o      (res)
  );

  assign pix_i.ready = cmd.in_ready;
  assign res_o.valid = cmd.out_valid;
  assign res_o.data  = res;

endmodule

// File: rtl/crms_checker.sv
// Port-level checker for circular_roi_mean_stddev_top, bound to the top.
// Depends on crms_pkg and circular_roi_mean_stddev_top_assert.svh.
`include "circular_roi_mean_stddev_top_assert.svh"

module crms_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                res_valid_i,
  input logic                res_ready_i,
  input crms_pkg::crms_res_t res_data_i
);
  import crms_pkg::*;

  `CRMS_ASSERT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i |=> res_valid_i, "result dropped before taken")
  `CRMS_ASSERT(a_res_stable, clk_i, rst_ni, res_valid_i && !res_ready_i |=> $stable(res_data_i), "result changed while pending")
  `CRMS_ASSERT(a_empty_zero, clk_i, rst_ni, res_valid_i && res_data_i.roi_empty |-> res_data_i.roi_count == '0 && res_data_i.mean_value == '0 && res_data_i.roi_std_dev == '0, "empty result not zero")
  `CRMS_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !res_valid_i, "result valid during reset")

endmodule

bind circular_roi_mean_stddev_top crms_checker u_crms_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .res_valid_i(res_o.valid),
  .res_ready_i(res_o.ready),
  .res_data_i (res_o.data)
);

// File: verif/tb.sv
// Testbench for circular_roi_mean_stddev_top: streams directed and random-size
// images with stall gaps and checks every ROI result against an in-bench
// predictor. Depends on crms_pkg, crms_stream_if and the RTL top level.
`timescale 1ns / 1ps

module tb;
  import crms_pkg::*;

  localparam int  SETTLE_CYCLES = 320;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int  PIXEL_TARGET  = 900;

  class roi_scoreboard;
    crms_res_t          pending[$];
    int                 errors;
    logic [SIDE_W-1:0]  side;
    logic signed [CTR_W-1:0] cx, cy;
    logic [RAD_W-1:0]   radius;
    longint             col, row, cnt, vsum;
    logic [63:0]        ssum;

    function new();
      errors = 0;
      side   = SIDE_RST;
      cx     = CENTER_RST;
      cy     = CENTER_RST;
      radius = RADIUS_RST;
      clear();
    endfunction

    function void clear();
      col = 0; row = 0; cnt = 0; vsum = 0; ssum = 0;
    endfunction

    function void write_reg(crms_reg_e idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_SIDE:     side   = v[SIDE_W-1:0];
        REG_CENTER_X: cx     = v;
        REG_CENTER_Y: cy     = v;
        REG_RADIUS:   radius = v[RAD_W-1:0];
        default: ;
      endcase
    endfunction

    // accepted pixel request: update accumulators, queue result on last
    function void note_pixel(crms_pix_t p);
      longint eff, dx, dy, pv, rr, mag, mean;
      logic [127:0] num, den, var_v, t;
      logic [63:0] root;
      crms_res_t r;
      eff = (side == 0) ? 1 : (side > MAX_SIDE_DEF) ? MAX_SIDE_DEF : side;
      pv  = p.pixel_value;
      dx  = col - longint'(cx);
      dy  = row - longint'(cy);
      rr  = longint'(radius) * longint'(radius);
      if (dx * dx + dy * dy < rr && cnt < longint'(MAX_SIDE_DEF) * MAX_SIDE_DEF) begin
        cnt++;
        vsum += pv;
        ssum += 64'(pv * pv);
      end
      if (!p.last_pixel) begin
        col++;
        if (col >= eff) begin
          col = 0;
          row++;
          if (row >= eff) row = 0;
        end
        return;
      end
      r = '0;
      if (cnt == 0) begin
        r.roi_empty = 1'b1;
      end else begin
        mag  = (vsum < 0) ? -vsum : vsum;
        mean = (vsum < 0) ? -((mag + cnt - 1) / cnt) : mag / cnt;
        num  = 128'(cnt) * 128'(ssum) - 128'(mag) * 128'(mag);
        den  = 128'(cnt) * 128'(cnt);
        var_v = num / den;
        root = 0;
        for (int i = 31; i >= 0; i--) begin
          t = 128'(root | (64'd1 << i));
          if (t * t <= var_v) root = t[63:0];
        end
        r.mean_value  = mean[PIX_W-1:0];
        r.roi_std_dev = root[STD_W-1:0];
        r.roi_count   = cnt[CNT_OUT_W-1:0];
      end
      pending.push_back(r);
      clear();
    endfunction

    function void check(crms_res_t got);
      crms_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.mean_value !== e.mean_value) begin
        $display("%0t: mean_value exp %0d got %0d", $realtime, e.mean_value,
                 got.mean_value);
        errors++;
      end
      if (got.roi_std_dev !== e.roi_std_dev) begin
        $display("%0t: roi_std_dev exp %0d got %0d", $realtime, e.roi_std_dev,
                 got.roi_std_dev);
        errors++;
      end
      if (got.roi_count !== e.roi_count) begin
        $display("%0t: roi_count exp %0d got %0d", $realtime, e.roi_count, got.roi_count);
        errors++;
      end
      if (got.roi_empty !== e.roi_empty) begin
        $display("%0t: roi_empty exp %0b got %0b", $realtime, e.roi_empty, got.roi_empty);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  longint cycles = 0;
  int burst_left = 0;
  int sent = 0;
  int stall_mode = 0;
  roi_scoreboard roi_sb;

  crms_pix_if pix ();
  crms_res_if res ();

  circular_roi_mean_stddev_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix),
    .res_o       (res)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    pix.valid = 1'b0;
    pix.data  = '0;
    res.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result sink with its own stall pattern
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res.valid && res.ready) roi_sb.check(res.data);
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       res.ready <= 1'b1;
        1:       res.ready <= ($urandom_range(0, 3) != 0);
        2:       res.ready <= ($urandom_range(0, 3) == 0);
        default: res.ready <= ($urandom_range(0, 40) == 0);
      endcase
    end
  end

  task automatic send_pixel(logic [PIX_W-1:0] v, logic last);
    crms_pix_t p;
    p.pixel_value = v;
    p.last_pixel  = last;
    pix.valid <= 1'b1;
    pix.data  <= p;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    roi_sb.note_pixel(p);
    sent++;
    if (burst_left == 0) begin
      pix.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (roi_sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(crms_reg_e idx, logic [CFG_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    roi_sb.write_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic configure(int side, int cx, int cy, int rad);
    write_cfg(REG_SIDE, CFG_W'(side));
    write_cfg(REG_CENTER_X, CFG_W'(cx));
    write_cfg(REG_CENTER_Y, CFG_W'(cy));
    write_cfg(REG_RADIUS, CFG_W'(rad));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 5))
      0:       return PIX_W'(-524288);
      1:       return PIX_W'(524287);
      2:       return PIX_W'($urandom_range(0, 64) - 32);
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic send_image(int len);
    for (int i = 0; i < len; i++) send_pixel(rand_pixel(), i == len - 1);
  endtask

  initial begin
    int side, len, cx, cy, rad;
    roi_sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: extremes, empty ROI, side clamps, wrap past image end
    send_pixel(PIX_W'(7), 1'b1);
    wait_idle();
    configure(4, 1, 2, 2);
    send_pixel(PIX_W'(524287), 1'b0);
    send_pixel(PIX_W'(-524288), 1'b0);
    for (int i = 0; i < 8; i++) send_pixel(i[0] ? PIX_W'(524287) : PIX_W'(-524288), 1'b0);
    send_pixel(PIX_W'(-524288), 1'b1);
    wait_idle();
    configure(0, 0, 0, 1);
    send_pixel(PIX_W'(100), 1'b0);
    send_pixel(PIX_W'(-3), 1'b1);
    wait_idle();
    configure(4095, -2048, 4095, 4095);
    send_image(4);
    wait_idle();
    configure(2048, 0, 0, 2048);
    send_image(3);
    wait_idle();
    configure(3, 8, 8, 0);
    send_image(2);

    // random images
    while (sent < PIXEL_TARGET) begin
      if ($urandom_range(0, 1) == 0) begin
        wait_idle();
        case ($urandom_range(0, 19))
          0:       side = 0;
          1:       side = 2048;
          2:       side = $urandom_range(0, 4095);
          3, 4:    side = $urandom_range(7, 40);
          default: side = $urandom_range(1, 6);
        endcase
        if ($urandom_range(0, 9) < 7) begin
          cx = $urandom_range(0, side + 3) - 2;
          cy = $urandom_range(0, side + 3) - 2;
        end else begin
          cx = $urandom_range(0, 8191);
          cy = $urandom_range(0, 8191);
        end
        case ($urandom_range(0, 9))
          0:       rad = $urandom_range(0, 1);
          1, 2:    rad = $urandom_range(0, 4095);
          default: rad = $urandom_range(0, side + 2);
        endcase
        configure(side, cx, cy, rad);
      end
      side = (roi_sb.side == 0) ? 1 : roi_sb.side;
      if (side > 12) len = $urandom_range(1, 30);
      else if ($urandom_range(0, 4) != 0) len = side * side;
      else len = $urandom_range(1, 2 * side * side + 2);
      send_image(len);
    end

    wait_idle();
    if (roi_sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/crms_pkg.sv
rtl/crms_stream_if.sv
rtl/crms_ctrl.sv
rtl/crms_datapath.sv
rtl/circular_roi_mean_stddev_top.sv
rtl/crms_checker.sv
verif/tb.sv
